@@ hdl/jpeg_dht_segment_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the DHT segment parser.
// All checks are clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef JPEG_DHT_SEGMENT_PARSER_ASSERT_SVH
`define JPEG_DHT_SEGMENT_PARSER_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define JDSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define JDSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/jdsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdsp_pkg
// Types and constants for the JPEG DHT segment parser.
// ----------------------------------------------------------------------------
package jdsp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MARK2  = 3'd1,
        PH_LENHI  = 3'd2,
        PH_LENLO  = 3'd3,
        PH_CLSID  = 3'd4,
        PH_COUNTS = 3'd5,
        PH_VALUES = 3'd6
    } phase_t;

    localparam logic [2:0] KIND_COUNT  = 3'd0;
    localparam logic [2:0] KIND_SYMBOL = 3'd1;
    localparam logic [2:0] KIND_COMMIT = 3'd2;
    localparam logic [2:0] KIND_OK     = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // Results one byte can cause at most.
    localparam int MAX_RESULTS = 3;
    // Result queue depth and index width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [7:0] seg_byte;
        logic       seg_first;
    } seg_in_t;

    typedef struct packed {
        logic [2:0] out_kind;
        logic       tbl_class;
        logic [1:0] tbl_id;
        logic [7:0] slot;
        logic [7:0] wr_value;
        logic       run_last;
    } seg_out_t;

    function automatic seg_out_t make_result(logic [2:0] kind, logic cls,
                                             logic [7:0] id, logic [7:0] slot,
                                             logic [7:0] val);
        seg_out_t r;
        r.out_kind  = kind;
        r.tbl_class = cls;
        r.tbl_id    = id[1:0];
        r.slot      = slot;
        r.wr_value  = val;
        r.run_last  = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/jpeg_dht_segment_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_dht_segment_parser
// Parses a JPEG DHT segment byte stream into count, symbol, commit and status
// result beats.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one segment byte per beat, s_data.seg_first marks the first
//   marker byte of a segment. m_ channel: result beats (count write, symbol
//   write, table commit, segment ok, error); run_last flags the last result
//   caused by one input byte.
//   Each accepted byte updates the parser state in the accept cycle and
//   pushes 0 to 3 results into a 4-entry result queue; a result is offered on
//   m_ from the queue once the results ahead of it have been taken.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and m_ready is high. s_ready needs 3 free queue entries, so a byte that
//   yields 2 or 3 results (the end of a table) holds the input until the
//   queue drains; it drains one result per cycle while m_ready is high.
//   Reset (aresetn low, synchronous) empties the queue and puts the parser in
//   idle, where bytes are dropped until a seg_first byte arrives.
//   When m_ready is held low the queue fills and s_ready drops; no result is
//   lost and the offered beat holds.
// ----------------------------------------------------------------------------
module jpeg_dht_segment_parser #(
    parameter int TABLE_LIMIT = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jdsp_pkg::seg_in_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output jdsp_pkg::seg_out_t m_data
);

    // Parser state
    jdsp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  phase_pos_reg, phase_pos_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        cur_class_reg, cur_class_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [11:0] count_sum_reg, count_sum_next;
    logic [8:0]  values_done_reg, values_done_next;

    // Result queue
    jdsp_pkg::seg_out_t queue_mem [jdsp_pkg::QUEUE_DEPTH];
    logic [jdsp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jdsp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jdsp_pkg::QCNT_W-1:0] count_reg, count_next;

    jdsp_pkg::seg_out_t res [jdsp_pkg::MAX_RESULTS];
    logic [1:0] res_n;

    logic s_fire, m_fire;
    logic [7:0] b;

    assign b       = s_data.seg_byte;
    assign s_ready = (count_reg <= jdsp_pkg::QCNT_W'(jdsp_pkg::QUEUE_DEPTH
                                                    - jdsp_pkg::MAX_RESULTS));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_fire  = m_valid && m_ready;
    assign m_data  = queue_mem[rd_ptr_reg];

    // Per-byte parse step
    always_comb begin
        logic        do_end;
        logic        do_bnd;
        logic [15:0] len_v;
        logic [11:0] sum_new;
        logic [8:0]  vd_new;

        phase_next       = phase_reg;
        phase_pos_next   = phase_pos_reg;
        bytes_left_next  = bytes_left_reg;
        cur_class_next   = cur_class_reg;
        cur_id_next      = cur_id_reg;
        count_sum_next   = count_sum_reg;
        values_done_next = values_done_reg;
        do_end  = 1'b0;
        do_bnd  = 1'b0;
        len_v   = {bytes_left_reg[7:0], b};
        sum_new = count_sum_reg + {4'b0000, b};
        vd_new  = values_done_reg + 9'd1;
        res_n   = 2'd0;
        for (int i = 0; i < jdsp_pkg::MAX_RESULTS; i++) begin
            res[i] = '0;
        end

        if (s_data.seg_first) begin
            phase_next = jdsp_pkg::PH_MARK2;
        end else begin
            unique case (phase_reg)
                jdsp_pkg::PH_MARK2: begin
                    phase_next = jdsp_pkg::PH_LENHI;
                end
                jdsp_pkg::PH_LENHI: begin
                    bytes_left_next = {8'h00, b};
                    phase_next      = jdsp_pkg::PH_LENLO;
                end
                jdsp_pkg::PH_LENLO: begin
                    if (len_v < 16'd2) begin
                        res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_ERROR,
                                                           1'b0, 8'h00, 8'h00, 8'h00);
                        res_n      = res_n + 2'd1;
                        phase_next = jdsp_pkg::PH_IDLE;
                    end else begin
                        bytes_left_next = len_v - 16'd2;
                        do_bnd          = 1'b1;
                    end
                end
                jdsp_pkg::PH_CLSID: begin
                    cur_class_next   = b[4];
                    cur_id_next      = b & 8'hEF;
                    count_sum_next   = '0;
                    values_done_next = '0;
                    phase_pos_next   = '0;
                    bytes_left_next  = bytes_left_reg - 16'd1;
                    phase_next       = jdsp_pkg::PH_COUNTS;
                end
                jdsp_pkg::PH_COUNTS: begin
                    res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_COUNT,
                                                       cur_class_reg, cur_id_reg,
                                                       {4'h0, phase_pos_reg} + 8'd1, b);
                    res_n           = res_n + 2'd1;
                    count_sum_next  = sum_new;
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (phase_pos_reg == 4'd15) begin
                        phase_pos_next = '0;
                        if (sum_new > 12'd256 || {4'h0, sum_new} > bytes_left_next) begin
                            res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_ERROR,
                                                               1'b0, 8'h00, 8'h00, 8'h00);
                            res_n      = res_n + 2'd1;
                            phase_next = jdsp_pkg::PH_IDLE;
                        end else if (sum_new == '0) begin
                            do_end = 1'b1;
                        end else begin
                            phase_next = jdsp_pkg::PH_VALUES;
                        end
                    end else begin
                        phase_pos_next = phase_pos_reg + 4'd1;
                    end
                end
                jdsp_pkg::PH_VALUES: begin
                    res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_SYMBOL,
                                                       cur_class_reg, cur_id_reg,
                                                       values_done_reg[7:0], b);
                    res_n            = res_n + 2'd1;
                    values_done_next = vd_new;
                    bytes_left_next  = bytes_left_reg - 16'd1;
                    if ({3'b000, vd_new} >= count_sum_reg) begin
                        do_end = 1'b1;
                    end
                end
                default: begin
                    phase_next = jdsp_pkg::PH_IDLE;
                end
            endcase

            // Table complete: commit unless the id is out of range
            if (do_end) begin
                if (cur_id_reg >= 8'(TABLE_LIMIT)) begin
                    res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_ERROR,
                                                       1'b0, 8'h00, 8'h00, 8'h00);
                    res_n      = res_n + 2'd1;
                    phase_next = jdsp_pkg::PH_IDLE;
                end else begin
                    res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_COMMIT,
                                                       cur_class_reg, cur_id_reg,
                                                       8'h00, 8'h00);
                    res_n      = res_n + 2'd1;
                    do_bnd     = 1'b1;
                end
            end

            // Table boundary: next table, clean end, or short leftover
            if (do_bnd) begin
                if (bytes_left_next > 16'd16) begin
                    phase_next = jdsp_pkg::PH_CLSID;
                end else if (bytes_left_next == 16'd0) begin
                    res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_OK,
                                                       1'b0, 8'h00, 8'h00, 8'h00);
                    res_n      = res_n + 2'd1;
                    phase_next = jdsp_pkg::PH_IDLE;
                end else begin
                    res[res_n] = jdsp_pkg::make_result(jdsp_pkg::KIND_ERROR,
                                                       1'b0, 8'h00, 8'h00, 8'h00);
                    res_n      = res_n + 2'd1;
                    phase_next = jdsp_pkg::PH_IDLE;
                end
            end
        end

        // Flag the last result of this byte
        for (int i = 0; i < jdsp_pkg::MAX_RESULTS; i++) begin
            res[i].run_last = (res_n != 2'd0) && (2'(i) == res_n - 2'd1);
        end
    end

    // Queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (s_fire) begin
            wr_ptr_next = wr_ptr_reg + jdsp_pkg::QPTR_W'(res_n);
            count_next  = count_next + jdsp_pkg::QCNT_W'(res_n);
        end
        if (m_fire) begin
            rd_ptr_next = rd_ptr_reg + jdsp_pkg::QPTR_W'(1);
            count_next  = count_next - jdsp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= jdsp_pkg::PH_IDLE;
            phase_pos_reg   <= '0;
            bytes_left_reg  <= '0;
            cur_class_reg   <= 1'b0;
            cur_id_reg      <= '0;
            count_sum_reg   <= '0;
            values_done_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            if (s_fire) begin
                phase_reg       <= phase_next;
                phase_pos_reg   <= phase_pos_next;
                bytes_left_reg  <= bytes_left_next;
                cur_class_reg   <= cur_class_next;
                cur_id_reg      <= cur_id_next;
                count_sum_reg   <= count_sum_next;
                values_done_reg <= values_done_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Push this byte's results into the queue
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < jdsp_pkg::MAX_RESULTS; i++) begin
                if (2'(i) < res_n) begin
                    queue_mem[wr_ptr_reg + jdsp_pkg::QPTR_W'(i)] <= res[i];
                end
            end
        end
    end

`include "jpeg_dht_segment_parser_assert.svh"

    `JDSP_ASSERT_IMP(a_queue_room, s_fire,
        ({1'b0, count_reg} + {2'b00, res_n}) <= 4'(jdsp_pkg::QUEUE_DEPTH),
        "result queue overflow")
    `JDSP_ASSERT_IMP(a_idle_silent, s_fire && !s_data.seg_first && phase_reg == jdsp_pkg::PH_IDLE,
        res_n == 2'd0, "result produced while idle")
    `JDSP_ASSERT_NEXT(a_first_restarts, s_fire && s_data.seg_first,
        phase_reg == jdsp_pkg::PH_MARK2, "first byte did not restart parser")
    `JDSP_ASSERT_IMP(a_values_bound, phase_reg == jdsp_pkg::PH_VALUES,
        {3'b000, values_done_reg} < count_sum_reg, "symbol index past count sum")

endmodule

@@ sim/jpeg_dht_segment_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_dht_segment_parser_test
// Self-checking bench for the DHT segment parser. A directed stream covers
// idle bytes, a short length, an empty segment, a restart and a zero-count
// table. A random stream follows with well-formed segments holding random
// tables, mixed with corrupted lengths, bad ids, oversized counts, leftovers,
// truncation and noise. A scoreboard predicts every result beat and checks
// the m_ channel in order while both sides idle at random.
// ----------------------------------------------------------------------------
module jpeg_dht_segment_parser_test;

    localparam int TABLE_LIMIT    = 4;
    localparam int STIM_ITEMS     = 220;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 100;

    class dht_scoreboard;
        jdsp_pkg::phase_t   phase;
        logic [3:0]         count_idx;
        logic [15:0]        remaining;
        logic               cur_ac;
        logic [7:0]         cur_dest;
        logic [11:0]        count_total;
        logic [8:0]         symbols_seen;
        jdsp_pkg::seg_out_t expected_q[$];
        jdsp_pkg::seg_out_t burst[$];
        int                 failures;
        int                 reported;

        function new();
            phase        = jdsp_pkg::PH_IDLE;
            count_idx    = '0;
            remaining    = '0;
            cur_ac       = 1'b0;
            cur_dest     = '0;
            count_total  = '0;
            symbols_seen = '0;
            failures     = 0;
            reported     = 0;
        endfunction

        function void emit(logic [2:0] kind, logic ac, logic [7:0] dest,
                           logic [7:0] pos, logic [7:0] val);
            jdsp_pkg::seg_out_t r;
            r.out_kind  = kind;
            r.tbl_class = ac;
            r.tbl_id    = dest[1:0];
            r.slot      = pos;
            r.wr_value  = val;
            r.run_last  = 1'b0;
            burst.push_back(r);
        endfunction

        function void abort_segment();
            phase = jdsp_pkg::PH_IDLE;
            emit(jdsp_pkg::KIND_ERROR, 1'b0, 8'd0, 8'd0, 8'd0);
        endfunction

        function void table_boundary();
            if (remaining > 16'd16) begin
                phase = jdsp_pkg::PH_CLSID;
            end else if (remaining == 16'd0) begin
                phase = jdsp_pkg::PH_IDLE;
                emit(jdsp_pkg::KIND_OK, 1'b0, 8'd0, 8'd0, 8'd0);
            end else begin
                abort_segment();
            end
        endfunction

        function void close_table();
            if (cur_dest >= TABLE_LIMIT) begin
                abort_segment();
            end else begin
                emit(jdsp_pkg::KIND_COMMIT, cur_ac, cur_dest, 8'd0, 8'd0);
                table_boundary();
            end
        endfunction

        // Advance the parser copy by one accepted byte and queue its results.
        function void note_byte(jdsp_pkg::seg_in_t item);
            logic [7:0]         b;
            logic [15:0]        len_word;
            jdsp_pkg::seg_out_t r;
            b = item.seg_byte;
            burst.delete();
            if (item.seg_first) begin
                phase = jdsp_pkg::PH_MARK2;
            end else begin
                case (phase)
                    jdsp_pkg::PH_MARK2: begin
                        phase = jdsp_pkg::PH_LENHI;
                    end
                    jdsp_pkg::PH_LENHI: begin
                        remaining = {8'd0, b};
                        phase     = jdsp_pkg::PH_LENLO;
                    end
                    jdsp_pkg::PH_LENLO: begin
                        len_word = {remaining[7:0], b};
                        if (len_word < 16'd2) begin
                            abort_segment();
                        end else begin
                            remaining = len_word - 16'd2;
                            table_boundary();
                        end
                    end
                    jdsp_pkg::PH_CLSID: begin
                        cur_ac       = b[4];
                        cur_dest     = b & 8'hEF;
                        count_total  = '0;
                        symbols_seen = '0;
                        count_idx    = '0;
                        remaining    = remaining - 16'd1;
                        phase        = jdsp_pkg::PH_COUNTS;
                    end
                    jdsp_pkg::PH_COUNTS: begin
                        emit(jdsp_pkg::KIND_COUNT, cur_ac, cur_dest,
                             {4'd0, count_idx} + 8'd1, b);
                        count_total = count_total + {4'd0, b};
                        remaining   = remaining - 16'd1;
                        if (count_idx == 4'd15) begin
                            count_idx = '0;
                            if (count_total > 12'd256 || {4'd0, count_total} > remaining) begin
                                abort_segment();
                            end else if (count_total == 12'd0) begin
                                close_table();
                            end else begin
                                phase = jdsp_pkg::PH_VALUES;
                            end
                        end else begin
                            count_idx = count_idx + 4'd1;
                        end
                    end
                    jdsp_pkg::PH_VALUES: begin
                        emit(jdsp_pkg::KIND_SYMBOL, cur_ac, cur_dest, symbols_seen[7:0], b);
                        symbols_seen = symbols_seen + 9'd1;
                        remaining    = remaining - 16'd1;
                        if ({3'd0, symbols_seen} >= count_total) begin
                            close_table();
                        end
                    end
                    default: begin
                        phase = jdsp_pkg::PH_IDLE;
                    end
                endcase
            end
            foreach (burst[i]) begin
                r          = burst[i];
                r.run_last = (i == burst.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        function string describe(jdsp_pkg::seg_out_t r);
            return $sformatf("kind=%0d class=%0d id=%0d slot=%0d value=%0d last=%0d",
                             r.out_kind, r.tbl_class, r.tbl_id, r.slot, r.wr_value,
                             r.run_last);
        endfunction

        function void check_result(jdsp_pkg::seg_out_t got);
            jdsp_pkg::seg_out_t want;
            if (expected_q.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: result beat with nothing expected: %s", describe(got));
                end
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: result mismatch: expected %s", describe(want));
                    $display("                        actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    jdsp_pkg::seg_in_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    jdsp_pkg::seg_out_t m_data;

    dht_scoreboard     sb = new();
    jdsp_pkg::seg_in_t stim_q[$];
    int                idle_cycles = 0;

    always #6 aclk = ~aclk;

    jpeg_dht_segment_parser #(
        .TABLE_LIMIT(TABLE_LIMIT)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Mostly short gaps, a few long ones, and now and then a stretch of none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put_byte(logic [7:0] b, logic first);
        jdsp_pkg::seg_in_t item;
        item.seg_byte  = b;
        item.seg_first = first;
        stim_q.push_back(item);
    endfunction

    task automatic add_segment();
        logic [7:0] body[$];
        int         cnt[16];
        int         ntab, nsym, r, len, keep;
        ntab = $urandom_range(1, 3);
        for (int t = 0; t < ntab; t++) begin
            if ($urandom_range(0, 99) < 80) begin
                body.push_back(8'($urandom) & 8'h13);
            end else begin
                body.push_back(8'($urandom));
            end
            foreach (cnt[j]) cnt[j] = 0;
            r = $urandom_range(0, 99);
            if (r < 6) begin
                nsym = -1;
            end else if (r < 20) begin
                nsym = 0;
            end else begin
                nsym = $urandom_range(1, 24);
            end
            // Oversized counts: no symbols follow, the parser stops after them.
            if (nsym < 0) begin
                foreach (cnt[j]) cnt[j] = $urandom_range(0, 255);
            end else begin
                repeat (nsym) cnt[$urandom_range(0, 15)]++;
            end
            foreach (cnt[j]) body.push_back(8'(cnt[j]));
            if (nsym > 0) begin
                repeat (nsym) body.push_back(8'($urandom));
            end
        end

        len  = body.size() + 2;
        keep = body.size();
        r    = $urandom_range(0, 99);
        if (r < 8) begin
            len = $urandom_range(0, 1);
        end else if (r < 18) begin
            nsym = $urandom_range(1, 20);
            repeat (nsym) body.push_back(8'($urandom));
            len  = len + nsym;
            keep = body.size();
        end else if (r < 26) begin
            len = len - $urandom_range(1, 17);
        end else if (r < 31) begin
            len = $urandom_range(0, 65535);
        end else if (r < 36) begin
            keep = $urandom_range(0, body.size() - 1);
        end

        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
        end
        r = $urandom_range(0, 99);
        put_byte(r < 70 ? 8'hFF : 8'($urandom), 1'b1);
        put_byte(r < 70 ? 8'hC4 : 8'($urandom), 1'b0);
        put_byte(8'(len >> 8), 1'b0);
        put_byte(8'(len), 1'b0);
        for (int j = 0; j < keep; j++) put_byte(body[j], 1'b0);
    endtask

    task automatic build_stimulus();
        // Ignored before any segment starts.
        put_byte(8'hFF, 1'b0);
        // Length below two, then a byte dropped after the error.
        put_byte(8'hFF, 1'b1);
        put_byte(8'hD8, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hAA, 1'b0);
        // Empty segment.
        put_byte(8'hFF, 1'b1);
        put_byte(8'hC4, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h02, 1'b0);
        // Start a segment and restart it before the length completes.
        put_byte(8'hFF, 1'b1);
        put_byte(8'hC4, 1'b0);
        // One AC table with no codes: last count, commit and ok on one byte.
        put_byte(8'hFF, 1'b1);
        put_byte(8'hC4, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h13, 1'b0);
        put_byte(8'h13, 1'b0);
        repeat (16) put_byte(8'h00, 1'b0);

        while (stim_q.size() < STIM_ITEMS) add_segment();
        // Cut the stream at the item count; the last segment may end early.
        stim_q = stim_q[0:STIM_ITEMS-1];
    endtask

    task automatic send_stream();
        int gap;
        int calm;
        calm = 0;
        foreach (stim_q[i]) begin
            gap = pick_gap(calm);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= stim_q[i];
            @(negedge aclk);
            while (!s_ready) @(negedge aclk);
            @(posedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int hold;
        int calm;
        hold = 0;
        calm = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                hold = pick_gap(calm);
            end
        end
    end

    // Sample between edges: the values seen here are the ones the next edge takes.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        send_stream();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
